// ===== rtl/core/ccs_pkg.sv =====
package ccs_pkg;

  localparam int unsigned LINE_BITS  = 24;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned ERR_LINE_W = 24;

  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_BODY   = 3'd2,
    MODE_STAR   = 3'd3,
    MODE_SQ     = 3'd4,
    MODE_DQ     = 3'd5,
    MODE_SQ_ESC = 3'd6,
    MODE_DQ_ESC = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_UNTERM = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef struct packed {
    logic [BYTE_W-1:0]     out_byte;
    kind_e                 kind;
    logic [ERR_LINE_W-1:0] error_line;
    logic                  last;
  } res_t;

endpackage

// ===== rtl/core/ccs_if.sv =====
interface ccs_in_if import ccs_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              end_of_stream;

  modport source (output valid, output in_byte, output end_of_stream, input ready);
  modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

interface ccs_out_if import ccs_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [BYTE_W-1:0]     out_byte;
  logic [1:0]            kind;
  logic [ERR_LINE_W-1:0] error_line;
  logic                  last;

  modport source (output valid, output out_byte, output kind, output error_line,
                  output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_line,
                  input last, output ready);
endinterface

// ===== rtl/core/c_comment_stripper.sv =====
// Channel | Dir | Payload                                   | Role
// in_i    | in  | in_byte[7:0], end_of_stream               | text bytes, end marker
// out_o   | out | out_byte[7:0], kind[1:0], error_line[23:0], | stripped bytes and
//         |     | last                                      | end-of-stream status
//
// An accepted transaction lands in an input register; the scanner consumes it
// once the output queue is empty or popping its last result, and loads its zero,
// one or two results into that two-slot queue. One transaction per cycle while
// each gives at most one result and the output is not stalled; the two results of
// one transaction leave the single output port in turn. Reset: normal text, line 1.
// A stalled output holds its result; the input register takes one more transaction.
module c_comment_stripper import ccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_in_if.sink    in_i,
  ccs_out_if.source out_o
);

  logic              in_vld_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_eos_q;

  mode_e                mode_q, mode_d;
  logic [LINE_BITS-1:0] line_q, line_d;
  logic [LINE_BITS-1:0] cline_q, cline_d;
  logic [LINE_BITS-1:0] line_nl;

  res_t       slot0_q, slot1_q;
  logic [1:0] cnt_q;
  res_t       res0, res1;
  logic [1:0] res_n;

  logic in_acc, out_pop, s1_fire, in_comment;

  function automatic mode_e after_text(logic [BYTE_W-1:0] c);
    mode_e m;
    m = MODE_NORMAL;
    if (c == CH_SQUOTE) m = MODE_SQ;
    else if (c == CH_DQUOTE) m = MODE_DQ;
    return m;
  endfunction

  assign out_pop    = out_o.valid && out_o.ready;
  assign s1_fire    = in_vld_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_pop));
  assign in_i.ready = !in_vld_q || s1_fire;
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_comment = (mode_q == MODE_BODY) || (mode_q == MODE_STAR);
  assign line_nl    = ((in_byte_q == CH_NL) && (line_q != '1)) ? line_q + 1'b1 : line_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (s1_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.in_byte;
      in_eos_q  <= in_i.end_of_stream;
    end
  end

  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    cline_d = cline_q;
    if (s1_fire) begin
      if (in_eos_q) begin
        mode_d  = MODE_NORMAL;
        line_d  = LINE_BITS'(1);
        cline_d = LINE_BITS'(1);
      end else begin
        line_d = line_nl;
        if (!in_comment) cline_d = line_nl;
        case (mode_q)
          MODE_NORMAL: begin
            mode_d = (in_byte_q == CH_SLASH) ? MODE_SLASH : after_text(in_byte_q);
          end
          MODE_SLASH: begin
            if (in_byte_q == CH_SLASH) mode_d = MODE_SLASH;
            else if (in_byte_q == CH_STAR) mode_d = MODE_BODY;
            else mode_d = after_text(in_byte_q);
          end
          MODE_BODY, MODE_STAR: begin
            if (in_byte_q == CH_STAR) mode_d = MODE_STAR;
            else if ((mode_q == MODE_STAR) && (in_byte_q == CH_SLASH)) mode_d = MODE_NORMAL;
            else mode_d = MODE_BODY;
          end
          MODE_SQ: begin
            if (in_byte_q == CH_SQUOTE) mode_d = MODE_NORMAL;
            else if (in_byte_q == CH_BSLASH) mode_d = MODE_SQ_ESC;
            else mode_d = MODE_SQ;
          end
          MODE_DQ: begin
            if (in_byte_q == CH_DQUOTE) mode_d = MODE_NORMAL;
            else if (in_byte_q == CH_BSLASH) mode_d = MODE_DQ_ESC;
            else mode_d = MODE_DQ;
          end
          MODE_SQ_ESC: mode_d = MODE_SQ;
          MODE_DQ_ESC: mode_d = MODE_DQ;
          default:     mode_d = MODE_NORMAL;
        endcase
      end
    end
  end

  always_comb begin
    res0  = '{out_byte: in_byte_q, kind: KIND_BYTE, error_line: '0, last: 1'b0};
    res1  = '{out_byte: in_byte_q, kind: KIND_BYTE, error_line: '0, last: 1'b0};
    res_n = 2'd0;
    if (in_eos_q) begin
      res1 = '{out_byte: '0, kind: KIND_END, error_line: '0, last: 1'b0};
      if (in_comment) begin
        res0  = '{out_byte: '0, kind: KIND_UNTERM,
                  error_line: ERR_LINE_W'(cline_q), last: 1'b0};
        res_n = 2'd1;
      end else if (mode_q == MODE_SLASH) begin
        res0.out_byte = CH_SLASH;
        res_n         = 2'd2;
      end else begin
        res0  = res1;
        res_n = 2'd1;
      end
    end else begin
      case (mode_q)
        MODE_NORMAL: begin
          if (in_byte_q != CH_SLASH) res_n = 2'd1;
        end
        MODE_SLASH: begin
          res0.out_byte = CH_SLASH;
          if (in_byte_q == CH_SLASH) begin
            res_n = 2'd1;
          end else if (in_byte_q == CH_STAR) begin
            res0.out_byte = CH_SPACE;
            res_n         = 2'd1;
          end else begin
            res_n = 2'd2;
          end
        end
        MODE_BODY, MODE_STAR: begin
          if (in_byte_q == CH_NL) res_n = 2'd1;
        end
        default: res_n = 2'd1;
      endcase
    end
    if (res_n == 2'd1) res0.last = 1'b1;
    if (res_n == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NORMAL;
      line_q  <= LINE_BITS'(1);
      cline_q <= LINE_BITS'(1);
      cnt_q   <= 2'd0;
    end else begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      cline_q <= cline_d;
      if (s1_fire) begin
        cnt_q <= res_n;
      end else if (out_pop) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      slot0_q <= res0;
      slot1_q <= res1;
    end else if (out_pop) begin
      slot0_q <= slot1_q;
    end
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.out_byte   = slot0_q.out_byte;
  assign out_o.kind       = slot0_q.kind;
  assign out_o.error_line = slot0_q.error_line;
  assign out_o.last       = slot0_q.last;

endmodule

// ===== rtl/core/ccs_checker.sv =====
module ccs_props import ccs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ccs_out_if.source out_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.out_byte)
      && $stable(out_o.kind) && $stable(out_o.last))
    else $error("stalled output transaction changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind != KIND_BYTE) |-> out_o.last && (out_o.out_byte == '0))
    else $error("status transaction not final or carries a byte");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind == KIND_UNTERM) |-> (out_o.error_line != '0))
    else $error("unterminated comment reported on line zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.kind != KIND_UNTERM) |-> (out_o.error_line == '0))
    else $error("line number on a non-error transaction");

endmodule

bind c_comment_stripper ccs_props u_ccs_props (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .out_o  (out_o)
);
